// ===== rtl/y2r_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and the saturation function of the YCbCr to RGB converter.
package y2r_pkg;

   // Width of every product and channel sum. This holds -70816..136882 with room.
   localparam int SUM_W = 19;

   // Range mode codes.
   localparam logic MODE_VIDEO = 1'b0;
   localparam logic MODE_FULL  = 1'b1;

   // Video (limited) range coefficients.
   localparam logic signed [SUM_W-1:0] VID_LUMA    = 19'sd298;
   localparam logic signed [SUM_W-1:0] VID_RED_V   = 19'sd409;
   localparam logic signed [SUM_W-1:0] VID_GREEN_U = 19'sd100;
   localparam logic signed [SUM_W-1:0] VID_GREEN_V = 19'sd208;
   localparam logic signed [SUM_W-1:0] VID_BLUE_U  = 19'sd516;

   // Full range coefficients; luma is scaled by 256, which is a shift.
   localparam logic signed [SUM_W-1:0] FULL_RED_V   = 19'sd359;
   localparam logic signed [SUM_W-1:0] FULL_GREEN_U = 19'sd88;
   localparam logic signed [SUM_W-1:0] FULL_GREEN_V = 19'sd183;
   localparam logic signed [SUM_W-1:0] FULL_BLUE_U  = 19'sd454;

   localparam logic signed [SUM_W-1:0] FRAC_ROUND   = 19'sd128;
   localparam logic signed [9:0]       LUMA_OFFSET  = 10'sd16;
   localparam logic signed [8:0]       CHROMA_OFFSET = 9'sd128;

   // Stage advance enables handed from the top level to each pixel datapath.
   typedef struct packed {
      logic adv1;
      logic adv2;
      logic adv3;
   } y2r_ctrl_type;

   // Chroma products shared by the upper and lower pixel.
   typedef struct packed {
      logic signed [SUM_W-1:0] red_v;
      logic signed [SUM_W-1:0] green_u;
      logic signed [SUM_W-1:0] green_v;
      logic signed [SUM_W-1:0] blue_u;
   } y2r_chroma_type;

   // Drops the 8 fraction bits and clamps to 0..255.
   function automatic logic [7:0] sat8(input logic signed [SUM_W-1:0] sum);
      logic [7:0] res;
      if (sum[SUM_W-1]) begin
         res = 8'd0;
      end else if (|sum[SUM_W-2:16]) begin
         res = 8'd255;
      end else begin
         res = sum[15:8];
      end
      return res;
   endfunction

endpackage

// ===== rtl/y2r_pixel.sv =====
`timescale 1ns / 1ps
// Three-stage datapath that turns one luma sample and the shared chroma products into RGB.
module y2r_pixel (
   input  logic                    clock,
   input  y2r_pkg::y2r_ctrl_type   ctrl,
   input  logic                    mode,
   input  logic [7:0]              luma,
   input  y2r_pkg::y2r_chroma_type chroma,
   output logic [7:0]              red,
   output logic [7:0]              green,
   output logic [7:0]              blue
);
   import y2r_pkg::*;

   logic signed [SUM_W-1:0] luma_term_ff, luma_term_in;
   logic signed [SUM_W-1:0] red_sum_ff, red_sum_in;
   logic signed [SUM_W-1:0] green_sum_ff, green_sum_in;
   logic signed [SUM_W-1:0] blue_sum_ff, blue_sum_in;
   logic [7:0]              red_ff, green_ff, blue_ff;
   logic signed [9:0]       luma_off;

   // Stage one: weighted luma. Values below 16 stay negative on purpose.
   always_comb begin
      luma_off = $signed({2'b00, luma}) - LUMA_OFFSET;
      if (mode == MODE_FULL) begin
         luma_term_in = $signed({3'b000, luma, 8'b0000_0000});
      end else begin
         luma_term_in = SUM_W'(luma_off) * VID_LUMA;
      end
   end

   // Stage two: channel sums with rounding.
   always_comb begin
      red_sum_in   = luma_term_ff + chroma.red_v + FRAC_ROUND;
      green_sum_in = luma_term_ff - chroma.green_u - chroma.green_v + FRAC_ROUND;
      blue_sum_in  = luma_term_ff + chroma.blue_u + FRAC_ROUND;
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv1) begin
         luma_term_ff <= luma_term_in;
      end
      if (ctrl.adv2) begin
         red_sum_ff   <= red_sum_in;
         green_sum_ff <= green_sum_in;
         blue_sum_ff  <= blue_sum_in;
      end
      // Stage three: saturation into the output register.
      if (ctrl.adv3) begin
         red_ff   <= sat8(red_sum_ff);
         green_ff <= sat8(green_sum_ff);
         blue_ff  <= sat8(blue_sum_ff);
      end
   end

   assign red   = red_ff;
   assign green = green_ff;
   assign blue  = blue_ff;

endmodule

// ===== rtl/ycbcr_to_rgb_pixel_pair_top.sv =====
`timescale 1ns / 1ps
// Top level of the BT.601 YCbCr 4:2:0 pixel pair to RGB converter.
//
// Each request carries one shared Cb/Cr pair and the two luma samples that use
// it, one from the upper and one from the lower row of a 4:2:0 row pair. The
// block answers every request with exactly one response holding an RGB pixel
// for each row, computed with BT.601 integer coefficients, 8 fraction bits,
// round half up, and saturation to 0..255. The csr port writes range_mode:
// 0 selects video range, 1 selects full range; it resets to video range and
// must only be written while no request is in flight. The datapath is a
// three-stage pipeline (coefficient products, channel sums, saturation into
// the response register); a request passes through these registers in order before
// its response is presented and can be taken, and one request per
// clock is taken at full throughput. Each stage
// carries its own valid bit and only moves when the stage after it is empty or
// moving, so backpressure on rsp_tready fills bubbles first and never drops or
// repeats a request.
module ycbcr_to_rgb_pixel_pair_top (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] upper_luma, [15:8] lower_luma, [23:16] cb_sample, [31:24] cr_sample
   input  logic [31:0] req_tdata,
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] upper_red, [15:8] upper_green, [23:16] upper_blue,
   // [31:24] lower_red, [39:32] lower_green, [47:40] lower_blue
   output logic [47:0] rsp_tdata,
   // Register write channel for range_mode.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);
   import y2r_pkg::*;

   logic           mode_ff;
   logic           v1_ff, v2_ff, v3_ff;
   y2r_ctrl_type   ctrl;
   y2r_chroma_type chroma_ff, chroma_in;
   logic signed [8:0]       cb_off, cr_off;
   logic signed [SUM_W-1:0] cb_ext, cr_ext;

   // The register is always writable; the user keeps writes to idle periods.
   assign csr_ready = 1'b1;

   // A stage advances when the stage after it is empty or advancing.
   always_comb begin
      ctrl.adv3 = !v3_ff || rsp_tready;
      ctrl.adv2 = !v2_ff || ctrl.adv3;
      ctrl.adv1 = !v1_ff || ctrl.adv2;
   end

   assign req_tready = ctrl.adv1;

   // Stage one for the chroma side: the four shared products.
   always_comb begin
      cb_off = $signed({1'b0, req_tdata[23:16]}) - CHROMA_OFFSET;
      cr_off = $signed({1'b0, req_tdata[31:24]}) - CHROMA_OFFSET;
      cb_ext = SUM_W'(cb_off);
      cr_ext = SUM_W'(cr_off);
      if (mode_ff == MODE_FULL) begin
         chroma_in.red_v   = cr_ext * FULL_RED_V;
         chroma_in.green_u = cb_ext * FULL_GREEN_U;
         chroma_in.green_v = cr_ext * FULL_GREEN_V;
         chroma_in.blue_u  = cb_ext * FULL_BLUE_U;
      end else begin
         chroma_in.red_v   = cr_ext * VID_RED_V;
         chroma_in.green_u = cb_ext * VID_GREEN_U;
         chroma_in.green_v = cr_ext * VID_GREEN_V;
         chroma_in.blue_u  = cb_ext * VID_BLUE_U;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_VIDEO;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_data;
         end
         if (ctrl.adv1) begin
            v1_ff <= req_tvalid;
         end
         if (ctrl.adv2) begin
            v2_ff <= v1_ff;
         end
         if (ctrl.adv3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv1) begin
         chroma_ff <= chroma_in;
      end
   end

   y2r_pixel u_upper (
      .clock  (clock),
      .ctrl   (ctrl),
      .mode   (mode_ff),
      .luma   (req_tdata[7:0]),
      .chroma (chroma_ff),
      .red    (rsp_tdata[7:0]),
      .green  (rsp_tdata[15:8]),
      .blue   (rsp_tdata[23:16])
   );

   y2r_pixel u_lower (
      .clock  (clock),
      .ctrl   (ctrl),
      .mode   (mode_ff),
      .luma   (req_tdata[15:8]),
      .chroma (chroma_ff),
      .red    (rsp_tdata[31:24]),
      .green  (rsp_tdata[39:32]),
      .blue   (rsp_tdata[47:40])
   );

   assign rsp_tvalid = v3_ff;

   // An accepted request always lands in stage one.
   a_req_enters: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> v1_ff)
      else $error("accepted request did not enter stage one");

   // A full, stalled pipeline must refuse new requests.
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && v2_ff && v3_ff && !rsp_tready) |-> !req_tready)
      else $error("request taken while pipeline full and stalled");

   // A valid sum stage that moves always produces a response.
   a_stage2_to_out: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && ctrl.adv3) |=> rsp_tvalid)
      else $error("sum stage advanced but no response appeared");

endmodule

// ===== bench/ycbcr_to_rgb_pixel_pair_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the YCbCr 4:2:0 pixel pair to RGB converter.
module ycbcr_to_rgb_pixel_pair_top_test;

   // The whole run must fit well inside this many cycles, even with random idling and
   // the long response hold-off.
   localparam int CYCLE_LIMIT = 100000;

   // Requests pack {cr_sample, cb_sample, lower_luma, upper_luma}, upper_luma lowest.
   // Responses pack the six channels with upper_red in the lowest byte.
   typedef struct packed {
      logic [7:0] lower_blue;
      logic [7:0] lower_green;
      logic [7:0] lower_red;
      logic [7:0] upper_blue;
      logic [7:0] upper_green;
      logic [7:0] upper_red;
   } rgb_pair_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_data   = 1'b0;

   // Expected response words, oldest first, one per accepted request.
   logic [47:0] expected_pixels[$];

   // The range mode that the block should hold right now. It starts at the reset value
   // and changes only when a register write completes.
   logic range_mode_now = y2r_pkg::MODE_VIDEO;

   // When set, neither side idles at random. Used for one long random phase and for the
   // backpressure test, where the sender keeps offering requests.
   bit steady_mode = 1'b0;

   // Cycles for which the receiver refuses responses; counted down by the receiver.
   int hold_left   = 0;
   int error_count = 0;
   int cycle_count = 0;

   string channel_name[6] = '{"upper_red", "upper_green", "upper_blue",
                              "lower_red", "lower_green", "lower_blue"};

   ycbcr_to_rgb_pixel_pair_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------

   // Rounds a weighted sum with 8 fraction bits (half up) and clamps it to 0..255.
   function automatic logic [7:0] clamp_channel(input int weighted);
      int rounded;
      rounded = weighted + 128;
      if (rounded < 0) begin
         return 8'd0;
      end
      if (rounded / 256 > 255) begin
         return 8'd255;
      end
      return 8'(rounded / 256);
   endfunction

   // Converts one pixel; u and v are the chroma samples with their offset removed.
   // The result is {blue, green, red}, red in the low byte.
   function automatic logic [23:0] convert_pixel(input int luma, input int u, input int v,
                                                 input logic mode);
      int scaled_luma;
      int red;
      int green;
      int blue;
      if (mode == y2r_pkg::MODE_FULL) begin
         scaled_luma = 256 * luma;
         red   = scaled_luma + 359 * v;
         green = scaled_luma - 88 * u - 183 * v;
         blue  = scaled_luma + 454 * u;
      end else begin
         // Luma below 16 goes negative here on purpose; only the final sum saturates.
         scaled_luma = 298 * (luma - 16);
         red   = scaled_luma + 409 * v;
         green = scaled_luma - 100 * u - 208 * v;
         blue  = scaled_luma + 516 * u;
      end
      return {clamp_channel(blue), clamp_channel(green), clamp_channel(red)};
   endfunction

   // Works out the full response word for one request word in the given mode.
   function automatic logic [47:0] predict_pair(input logic [31:0] word, input logic mode);
      rgb_pair_type pair;
      int u;
      int v;
      u = int'(word[23:16]) - 128;
      v = int'(word[31:24]) - 128;
      {pair.upper_blue, pair.upper_green, pair.upper_red} =
         convert_pixel(int'(word[7:0]), u, v, mode);
      {pair.lower_blue, pair.lower_green, pair.lower_red} =
         convert_pixel(int'(word[15:8]), u, v, mode);
      return pair;
   endfunction

   // ---------------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [47:0] got,
                                  input logic [47:0] want);
      $display("MISMATCH cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
      error_count++;
   endtask

   // Every accepted response is compared, channel by channel, with the oldest
   // expectation. Values are read at the edge, before any update of this time step.
   always @(posedge clock) begin
      logic [47:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch("response with no request waiting", rsp_tdata, '0);
         end else begin
            want = expected_pixels.pop_front();
            for (int i = 0; i < 6; i++) begin
               if (rsp_tdata[8*i +: 8] !== want[8*i +: 8]) begin
                  report_mismatch(channel_name[i], rsp_tdata, want);
               end
            end
         end
      end
   end

   // The receiver accepts responses at random, except during a hold-off, which it
   // counts down itself, and during steady stretches, where it never stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (steady_mode) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= 35);
      end
   end

   // Watchdog: a hung handshake or a lost response ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------

   // Sends one request. Outside steady stretches the sender idles first for a random
   // number of cycles, driving junk data with valid low. The expectation is queued
   // right at the accepting edge, so it is always in place before the response.
   task automatic send_pair(input logic [7:0] upper, input logic [7:0] lower,
                            input logic [7:0] cb, input logic [7:0] cr);
      logic [31:0] word;
      word = {cr, cb, lower, upper};
      while (!steady_mode && $urandom_range(99) < 35) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      expected_pixels.push_back(predict_pair(word, range_mode_now));
   endtask

   // Stops offering requests and waits until every response is back, and then waits on
   // so that any stray response would still be seen before the next step.
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // Writes range_mode. The block must be idle for this, so the pipeline drains first.
   task automatic write_range_mode(input logic mode);
      drain_pipeline();
      csr_valid <= 1'b1;
      csr_data  <= mode;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      range_mode_now = mode;
   endtask

   // Random sample, weighted toward the values where the conversion saturates or
   // sits at the edges of video range.
   function automatic logic [7:0] pick_sample();
      int sel;
      sel = $urandom_range(99);
      if (sel < 8)  return 8'd0;
      if (sel < 16) return 8'd255;
      if (sel < 20) return 8'd16;
      if (sel < 24) return 8'd235;
      if (sel < 28) return 8'd240;
      if (sel < 32) return 8'd128;
      return 8'($urandom_range(255));
   endfunction

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Without any register write the block must convert with video range.
   task automatic test_reset_default_mode();
      send_pair(8'd16,  8'd235, 8'd128, 8'd128);
      send_pair(8'd0,   8'd255, 8'd0,   8'd255);
      send_pair(8'd128, 8'd64,  8'd200, 8'd40);
      send_pair(8'd255, 8'd0,   8'd255, 8'd0);
   endtask

   // Video range extremes, including luma below 16 and both saturation directions.
   task automatic test_video_extremes();
      write_range_mode(y2r_pkg::MODE_VIDEO);
      send_pair(8'd0,   8'd255, 8'd128, 8'd128);
      send_pair(8'd255, 8'd255, 8'd255, 8'd255);
      send_pair(8'd0,   8'd0,   8'd0,   8'd0);
      send_pair(8'd0,   8'd0,   8'd255, 8'd255);
      send_pair(8'd255, 8'd0,   8'd255, 8'd0);
      send_pair(8'd5,   8'd15,  8'd128, 8'd128);
      send_pair(8'd1,   8'd14,  8'd170, 8'd90);
      send_pair(8'd235, 8'd16,  8'd16,  8'd240);
   endtask

   // Full range extremes.
   task automatic test_full_extremes();
      write_range_mode(y2r_pkg::MODE_FULL);
      send_pair(8'd0,   8'd255, 8'd128, 8'd128);
      send_pair(8'd255, 8'd255, 8'd255, 8'd255);
      send_pair(8'd0,   8'd0,   8'd0,   8'd0);
      send_pair(8'd255, 8'd0,   8'd0,   8'd255);
      send_pair(8'd0,   8'd255, 8'd255, 8'd0);
      send_pair(8'd128, 8'd64,  8'd170, 8'd85);
   endtask

   // Random pixel pairs in four phases that alternate the range mode. The third
   // phase runs with no idling on either side, so the pipeline runs at full rate.
   task automatic test_random_phases();
      for (int phase = 0; phase < 4; phase++) begin
         write_range_mode(phase[0] ? y2r_pkg::MODE_VIDEO : y2r_pkg::MODE_FULL);
         steady_mode = (phase == 2);
         repeat (230) send_pair(pick_sample(), pick_sample(), pick_sample(), pick_sample());
         steady_mode = 1'b0;
      end
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering
   // requests, so the pipeline fills up and must stall its input without losing any.
   task automatic test_backpressure();
      write_range_mode(1'($urandom_range(1)));
      steady_mode = 1'b1;
      hold_left   = 150;
      repeat (40) send_pair(pick_sample(), pick_sample(), pick_sample(), pick_sample());
      steady_mode = 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_default_mode();
      test_video_extremes();
      test_full_extremes();
      test_random_phases();
      test_backpressure();

      // Every response must be back; the extra cycles catch any stray one.
      drain_pipeline();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
